@@ sv/mpa_pkg.sv @@
// shared types and constants for the max pooling with argmax block
package mpa_pkg;

   // width of the position field of a result
   localparam int POS_BITS = 20;

   // configuration port geometry
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 11;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WINDOW_SIZE  = 2'd0,
      CSR_STRIDE       = 2'd1,
      CSR_PLANE_WIDTH  = 2'd2,
      CSR_PLANE_HEIGHT = 2'd3
   } csr_index_type;

   // register widths
   localparam int WS_REG_BITS     = 4;
   localparam int STRIDE_REG_BITS = 4;
   localparam int DIM_REG_BITS    = 11;

   // stride limit and its phase counter width
   localparam int MAX_STRIDE  = 8;
   localparam int STRIDE_BITS = 4;
   localparam int PHASE_BITS  = 3;

   // reset values of the configuration registers
   localparam logic [WS_REG_BITS-1:0]     WS_RESET     = 4'd2;
   localparam logic [STRIDE_REG_BITS-1:0] STRIDE_RESET = 4'd2;
   localparam logic [DIM_REG_BITS-1:0]    DIM_RESET    = 11'd32;

endpackage

@@ sv/mpa_req_if.sv @@
// input channel: one signed pixel per transaction
interface mpa_req_if #(
   parameter int PIXEL_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [PIXEL_BITS-1:0] pixel_value;

   modport source (output valid, output pixel_value, input ready);
   modport sink   (input valid, input pixel_value, output ready);
endinterface

@@ sv/mpa_rsp_if.sv @@
// result channel: window maximum, its position and the end of plane flag
interface mpa_rsp_if
   import mpa_pkg::*;
#(
   parameter int PIXEL_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [PIXEL_BITS-1:0] max_value;
   logic [POS_BITS-1:0]          argmax_pos;
   logic                         last_in_plane;

   modport source (output valid, output max_value, output argmax_pos, output last_in_plane,
                   input ready);
   modport sink   (input valid, input max_value, input argmax_pos, input last_in_plane,
                   output ready);
endinterface

@@ sv/mpa_ram.sv @@
// generic single write port ram with registered read
module mpa_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

@@ sv/max_pool_2d_argmax_core.sv @@
// max pooling with argmax over a raster pixel stream, one pixel per cycle unless the output stalls
// path: a result passes the stage 1, stage 2 and output registers after its bottom-right pixel
// throughput: one pixel per cycle unless the output stalls, set by the single-pass compare trees
// row store: one ram bank per row slot, read once per cycle at the current column unless stalled
// reset: synchronous, clears counters, pipeline valids and csr registers, not data or the row store
module max_pool_2d_argmax_core
   import mpa_pkg::*;
#(
   parameter int MAX_WINDOW = 8,
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int PIXEL_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   mpa_req_if.sink                   req_ch,
   mpa_rsp_if.source                 rsp_ch
);
   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int WSB = $clog2(MAX_WINDOW + 1);
   localparam int KB  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int EW  = PIXEL_BITS + POS_BITS;

   typedef logic signed [PIXEL_BITS-1:0] pix_type;

   // configuration registers
   logic [WS_REG_BITS-1:0]     ws_reg_ff;
   logic [STRIDE_REG_BITS-1:0] stride_reg_ff;
   logic [DIM_REG_BITS-1:0]    width_reg_ff;
   logic [DIM_REG_BITS-1:0]    height_reg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_reg_ff     <= WS_RESET;
         stride_reg_ff <= STRIDE_RESET;
         width_reg_ff  <= DIM_RESET;
         height_reg_ff <= DIM_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_WINDOW_SIZE:  ws_reg_ff     <= csr_data[WS_REG_BITS-1:0];
            CSR_STRIDE:       stride_reg_ff <= csr_data[STRIDE_REG_BITS-1:0];
            CSR_PLANE_WIDTH:  width_reg_ff  <= csr_data;
            CSR_PLANE_HEIGHT: height_reg_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // effective, clamped settings
   logic [WSB-1:0]         ws_eff;
   logic [STRIDE_BITS-1:0] s_eff;
   logic [WW-1:0]          w_eff;
   logic [HW-1:0]          h_eff;

   always_comb begin
      if (ws_reg_ff == '0) ws_eff = WSB'(1);
      else if (32'(ws_reg_ff) > MAX_WINDOW) ws_eff = WSB'(MAX_WINDOW);
      else ws_eff = WSB'(ws_reg_ff);
      if (stride_reg_ff == '0) s_eff = STRIDE_BITS'(1);
      else if (32'(stride_reg_ff) > MAX_STRIDE) s_eff = STRIDE_BITS'(MAX_STRIDE);
      else s_eff = STRIDE_BITS'(stride_reg_ff);
      if (width_reg_ff == '0) w_eff = WW'(1);
      else if (32'(width_reg_ff) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
      else w_eff = WW'(width_reg_ff);
      if (height_reg_ff == '0) h_eff = HW'(1);
      else if (32'(height_reg_ff) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
      else h_eff = HW'(height_reg_ff);
   end

   // pipeline advance, each stage moves when its successor has room
   logic out_v_ff, s2_v_ff, s1_v_ff;
   logic en0, en1, en2, req_take;

   assign en2      = !out_v_ff || rsp_ch.ready;
   assign en1      = !s2_v_ff || en2;
   assign en0      = !s1_v_ff || en1;
   assign req_ch.ready = en0;
   assign req_take = req_ch.valid && en0;

   // position counters and stride phases
   logic [CW-1:0]          col_ff, col_in;
   logic [RW-1:0]          row_ff, row_in;
   logic [KB-1:0]          rslot_ff, rslot_in;
   logic [POS_BITS-1:0]    rowbase_ff, rowbase_in;
   logic [PHASE_BITS-1:0]  hph_ff, hph_in, vph_ff, vph_in;
   logic                   col_last, row_last, h_al, v_al, plane_last;
   logic [WW:0]            col_ext, ws_m1_w;
   logic [HW:0]            row_ext, ws_m1_h;
   logic [PHASE_BITS-1:0]  s_m1;

   always_comb begin
      col_ext   = (WW + 1)'(col_ff);
      row_ext   = (HW + 1)'(row_ff);
      ws_m1_w   = (WW + 1)'(ws_eff) - (WW + 1)'(1);
      ws_m1_h   = (HW + 1)'(ws_eff) - (HW + 1)'(1);
      s_m1      = PHASE_BITS'(s_eff - STRIDE_BITS'(1));
      col_last  = col_ext >= ((WW + 1)'(w_eff) - (WW + 1)'(1));
      row_last  = row_ext >= ((HW + 1)'(h_eff) - (HW + 1)'(1));
      // window origin sits on a stride multiple
      h_al      = (col_ext >= ws_m1_w) && ((col_ext == ws_m1_w) || (hph_ff == '0));
      v_al      = (row_ext >= ws_m1_h) && ((row_ext == ws_m1_h) || (vph_ff == '0));
      plane_last = ((col_ext + (WW + 1)'(s_eff)) >= (WW + 1)'(w_eff))
                && ((row_ext + (HW + 1)'(s_eff)) >= (HW + 1)'(h_eff));

      col_in     = col_ff;
      row_in     = row_ff;
      rslot_in   = rslot_ff;
      rowbase_in = rowbase_ff;
      hph_in     = hph_ff;
      vph_in     = vph_ff;
      if (col_last) begin
         col_in = '0;
         hph_in = '0;
         if (row_last) begin
            row_in     = '0;
            rslot_in   = '0;
            rowbase_in = '0;
            vph_in     = '0;
         end else begin
            row_in     = row_ff + RW'(1);
            rslot_in   = (32'(rslot_ff) >= MAX_WINDOW - 1) ? '0 : rslot_ff + KB'(1);
            rowbase_in = rowbase_ff + POS_BITS'(w_eff);
            vph_in     = v_al ? s_m1 : vph_ff - PHASE_BITS'(1);
         end
      end else begin
         col_in = col_ff + CW'(1);
         hph_in = h_al ? s_m1 : hph_ff - PHASE_BITS'(1);
      end
   end

   // stage 1: pixel window and position context of the newest pixel
   pix_type             window_ff [MAX_WINDOW];
   logic [CW-1:0]       s1_col_ff;
   logic [POS_BITS-1:0] s1_rowbase_ff;
   logic [KB-1:0]       s1_rslot_ff;
   logic                s1_hal_ff, s1_val_ff, s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         rslot_ff   <= '0;
         rowbase_ff <= '0;
         hph_ff     <= '0;
         vph_ff     <= '0;
         s1_v_ff    <= 1'b0;
      end else begin
         if (req_take) begin
            col_ff     <= col_in;
            row_ff     <= row_in;
            rslot_ff   <= rslot_in;
            rowbase_ff <= rowbase_in;
            hph_ff     <= hph_in;
            vph_ff     <= vph_in;
         end
         if (en0) begin
            s1_v_ff <= req_ch.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         window_ff[0]  <= req_ch.pixel_value;
         for (int k = 1; k < MAX_WINDOW; k++) begin
            window_ff[k] <= window_ff[k-1];
         end
         s1_col_ff     <= col_ff;
         s1_rowbase_ff <= rowbase_ff;
         s1_rslot_ff   <= rslot_ff;
         s1_hal_ff     <= h_al;
         s1_val_ff     <= v_al;
         s1_last_ff    <= plane_last;
      end
   end

   // horizontal best: oldest pixel first, a later one wins only if strictly larger
   pix_type             hb_val;
   logic [KB-1:0]       hb_k;
   logic [POS_BITS-1:0] hb_pos;

   always_comb begin
      hb_val = window_ff[0];
      hb_k   = '0;
      for (int k = MAX_WINDOW - 1; k >= 0; k--) begin
         if (k < int'(ws_eff)) begin
            if ((k == int'(ws_eff) - 1) || (window_ff[k] > hb_val)) begin
               hb_val = window_ff[k];
               hb_k   = KB'(k);
            end
         end
      end
      hb_pos = s1_rowbase_ff + POS_BITS'(s1_col_ff) - POS_BITS'(hb_k);
   end

   // row store, one bank per row slot
   logic          st_we;
   logic [EW-1:0] bank_rd [MAX_WINDOW];

   assign st_we = en1 && s1_v_ff && s1_hal_ff;

   for (genvar b = 0; b < MAX_WINDOW; b++) begin : g_bank
      mpa_ram #(
         .WIDTH (EW),
         .DEPTH (MAX_WIDTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (st_we && (32'(s1_rslot_ff) == b)),
         .wr_addr (s1_col_ff),
         .wr_data ({hb_val, hb_pos}),
         .rd_en   (en1),
         .rd_addr (s1_col_ff),
         .rd_data (bank_rd[b])
      );
   end

   // stage 2: horizontal result of the bottom row, store reads arrive alongside
   pix_type             s2_val_ff;
   logic [POS_BITS-1:0] s2_pos_ff;
   logic [KB-1:0]       s2_rslot_ff;
   logic                s2_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en1) begin
         s2_v_ff <= s1_v_ff && s1_hal_ff && s1_val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s2_val_ff   <= hb_val;
         s2_pos_ff   <= hb_pos;
         s2_rslot_ff <= s1_rslot_ff;
         s2_last_ff  <= s1_last_ff;
      end
   end

   // vertical best: top row first, a lower row wins only if strictly larger
   pix_type             vb_val;
   logic [POS_BITS-1:0] vb_pos;
   pix_type             e_val;
   logic [POS_BITS-1:0] e_pos;
   int                  bsel;

   always_comb begin
      vb_val = s2_val_ff;
      vb_pos = s2_pos_ff;
      e_val  = s2_val_ff;
      e_pos  = s2_pos_ff;
      bsel   = 0;
      for (int j = MAX_WINDOW - 1; j >= 0; j--) begin
         if (j < int'(ws_eff)) begin
            if (j == 0) begin
               e_val = s2_val_ff;
               e_pos = s2_pos_ff;
            end else begin
               bsel = int'(s2_rslot_ff) - j;
               if (bsel < 0) bsel = bsel + MAX_WINDOW;
               e_val = pix_type'(bank_rd[bsel][EW-1:POS_BITS]);
               e_pos = bank_rd[bsel][POS_BITS-1:0];
            end
            if ((j == int'(ws_eff) - 1) || (e_val > vb_val)) begin
               vb_val = e_val;
               vb_pos = e_pos;
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en2) begin
         out_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         rsp_ch.max_value     <= vb_val;
         rsp_ch.argmax_pos    <= vb_pos;
         rsp_ch.last_in_plane <= s2_last_ff;
      end
   end

   assign rsp_ch.valid = out_v_ff;

   // a stalled result stays until it is taken
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !rsp_ch.ready |=> out_v_ff)
      else $error("result dropped while stalled");

   // a window waiting in stage 2 is not lost when the output is blocked
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff && !en2 |=> s2_v_ff)
      else $error("stage 2 item lost");

   // the store is written only on a horizontally aligned transfer
   a_store_write: assert property (@(posedge clock) disable iff (reset)
      st_we |-> (s1_v_ff && s1_hal_ff && en1))
      else $error("unexpected store write");

endmodule
